>>> rtl/assert_macros.svh
// shared assertion macros, all sampled on the rising clock edge and off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold in every cycle
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequence in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/cfps_pkg.sv
`default_nettype none

package cfps_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int WORD_BYTES = DATA_WIDTH / 8;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int LOG2_WIDTH = 5;
   localparam int TIMEOUT_WIDTH = 16;

   // request codes
   localparam logic [1:0] OP_PROGRAM = 2'd0;
   localparam logic [1:0] OP_ERASE = 2'd1;
   localparam logic [1:0] OP_READ_DATA = 2'd2;
   localparam logic [1:0] OP_TICK = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_READ = 2'd1;
   localparam logic [1:0] KIND_DONE = 2'd2;
   localparam logic [1:0] KIND_FAIL = 2'd3;

   // flash commands, one byte per 16-bit half
   localparam logic [7:0] CMD_READ_ID = 8'h90;
   localparam logic [7:0] CMD_CONFIGURE = 8'h60;
   localparam logic [7:0] CMD_CONFIRM = 8'hd0;
   localparam logic [7:0] CMD_PROGRAM = 8'h40;
   localparam logic [7:0] CMD_ERASE = 8'h20;
   localparam logic [7:0] CMD_CLEAR_STATUS = 8'h50;

   // status bits
   localparam logic [7:0] ST_READY = 8'h80;
   localparam logic [7:0] ST_ERASE_ERR = 8'h20;
   localparam logic [7:0] ST_PROG_ERR = 8'h10;
   localparam logic [7:0] ST_VPEN_LOW = 8'h08;
   localparam logic [7:0] ST_PROTECTED = 8'h02;
   localparam logic [7:0] ID_LOCKED = 8'h01;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BANK0_BASE = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BANK1_BASE = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BANK0_LENGTH = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REGION_BOUNDARY = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REGION0_LOG2 = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REGION1_LOG2 = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TIMEOUT = 3'd6;

   // register reset values
   localparam logic [DATA_WIDTH-1:0] BANK0_LENGTH_RESET = '1;
   localparam logic [DATA_WIDTH-1:0] REGION_BOUNDARY_RESET = '1;
   localparam logic [LOG2_WIDTH-1:0] BLOCK_LOG2_RESET = 5'd17;
   localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET = 16'(6 * 1000);
   localparam logic [LOG2_WIDTH-1:0] BLOCK_LOG2_MIN = 5'd8;
   localparam logic [LOG2_WIDTH-1:0] BLOCK_LOG2_MAX = 5'd24;

   typedef struct packed {
      logic [1:0]            op;
      logic [DATA_WIDTH-1:0] offset;
      logic [DATA_WIDTH-1:0] wdata;
      logic [WORD_BYTES-1:0] byte_enable;
   } req_type;

   typedef struct packed {
      logic [1:0]            kind;
      logic [DATA_WIDTH-1:0] bus_address;
      logic [DATA_WIDTH-1:0] bus_data;
      logic                  last;
   } rsp_type;

   // settings the address map needs
   typedef struct packed {
      logic [DATA_WIDTH-1:0] bank0_base;
      logic [DATA_WIDTH-1:0] bank1_adjust;   // bank1_base - bank0_length
      logic [DATA_WIDTH-1:0] bank0_length;
      logic [DATA_WIDTH-1:0] region_boundary;
      logic [LOG2_WIDTH-1:0] region0_log2;
      logic [LOG2_WIDTH-1:0] region1_log2;
   } map_cfg_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] word_address;
      logic [DATA_WIDTH-1:0] block_address;
      logic [DATA_WIDTH-1:0] page;
   } map_type;

   function automatic logic [DATA_WIDTH-1:0] both_halves(input logic [7:0] value);
      return {8'h00, value, 8'h00, value};
   endfunction

   function automatic rsp_type make_rsp(input logic [1:0] kind,
                                        input logic [DATA_WIDTH-1:0] address,
                                        input logic [DATA_WIDTH-1:0] data);
      rsp_type r;
      r.kind = kind;
      r.bus_address = address;
      r.bus_data = data;
      r.last = 1'b0;
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/cfps_addr_map.sv
`default_nettype none

module cfps_addr_map (
   input  logic [cfps_pkg::DATA_WIDTH-1:0] offset,
   input  cfps_pkg::map_cfg_type           cfg,
   output cfps_pkg::map_type               map
);
   import cfps_pkg::*;

   logic [LOG2_WIDTH-1:0] raw_log2;
   logic [LOG2_WIDTH-1:0] block_log2;
   logic [DATA_WIDTH-1:0] mask;
   logic [DATA_WIDTH-1:0] phys;

   always_comb begin
      raw_log2 = (offset < cfg.region_boundary) ? cfg.region0_log2 : cfg.region1_log2;
      priority if (raw_log2 < BLOCK_LOG2_MIN) begin
         block_log2 = BLOCK_LOG2_MIN;
      end else if (raw_log2 > BLOCK_LOG2_MAX) begin
         block_log2 = BLOCK_LOG2_MAX;
      end else begin
         block_log2 = raw_log2;
      end
      mask = ~((DATA_WIDTH'(1) << block_log2) - DATA_WIDTH'(1));
      phys = (offset < cfg.bank0_length) ? offset + cfg.bank0_base
                                         : offset + cfg.bank1_adjust;
      map.word_address = {phys[DATA_WIDTH-1:2], 2'b00};
      map.block_address = phys & mask;
      map.page = offset & mask;
   end

endmodule

`default_nettype wire

>>> rtl/cfi_flash_program_erase_sequencer.sv
// response: the first bus word of an item is offered in the cycle after the item is taken
// throughput: one item per cycle while items cause at most one word and each word is
//   taken as it is offered; an item that causes more words (up to three) holds the
//   request side until its last word leaves the single result port
// reset: synchronous, active high; sequencer idle, no page unlocked, registers at defaults
`default_nettype none
`include "assert_macros.svh"

module cfi_flash_program_erase_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  cfps_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output cfps_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [cfps_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [cfps_pkg::DATA_WIDTH-1:0]     csr_wdata
);
   import cfps_pkg::*;

   // sequencer phases
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_LOCK_WAIT = 2'd1;     // waiting for the ReadID lock word
   localparam logic [1:0] PH_UNLOCK_POLL = 2'd2;   // polling status after clearing locks
   localparam logic [1:0] PH_OP_POLL = 2'd3;       // polling status after program or erase

   localparam int RSP_DEPTH = 3;

   // configuration registers
   map_cfg_type                  map_cfg_ff, map_cfg_in;
   logic [DATA_WIDTH-1:0]        bank1_base_ff, bank1_base_in;
   logic [TIMEOUT_WIDTH-1:0]     timeout_ff, timeout_in;

   // sequencer state
   logic [1:0]                   phase_ff, phase_in;
   logic                         is_erase_ff, is_erase_in;
   logic [DATA_WIDTH-1:0]        word_address_ff, word_address_in;
   logic [DATA_WIDTH-1:0]        block_address_ff, block_address_in;
   logic [DATA_WIDTH-1:0]        pending_word_ff, pending_word_in;
   logic [DATA_WIDTH-1:0]        last_page_ff, last_page_in;
   logic [TIMEOUT_WIDTH-1:0]     poll_count_ff, poll_count_in;

   // result buffer: words of one item, head at entry 0
   rsp_type                      rsp_buf_ff [RSP_DEPTH];
   rsp_type                      rsp_new [RSP_DEPTH];
   logic [1:0]                   rsp_cnt_ff, rsp_cnt_in;
   logic [1:0]                   new_cnt;

   map_type                      map;
   logic                         req_fire;
   logic                         rsp_pop;

   // working values of the step
   logic                         cur_erase;
   logic [DATA_WIDTH-1:0]        cur_word, cur_block, target, status_mask;
   logic [DATA_WIDTH-1:0]        packed_word;
   logic                         do_unlock, do_operation, do_clear_locks;
   logic                         do_fail, do_done, do_poll_read, poll_done;

   cfps_addr_map u_addr_map (
      .offset (req_data.offset),
      .cfg    (map_cfg_ff),
      .map    (map)
   );

   // handshakes: a new item may enter while the last buffered word leaves
   assign rsp_valid = (rsp_cnt_ff != 2'd0);
   assign rsp_data  = rsp_buf_ff[0];
   assign rsp_pop   = rsp_valid && rsp_ready;
   assign req_ready = (rsp_cnt_ff == 2'd0) || ((rsp_cnt_ff == 2'd1) && rsp_ready);
   assign req_fire  = req_valid && req_ready;

   // configuration; the bank 1 adjustment is kept ready so mapping needs one add
   always_comb begin
      map_cfg_in = map_cfg_ff;
      bank1_base_in = bank1_base_ff;
      timeout_in = timeout_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BANK0_BASE: map_cfg_in.bank0_base = csr_wdata;
            CSR_BANK1_BASE: begin
               bank1_base_in = csr_wdata;
               map_cfg_in.bank1_adjust = csr_wdata - map_cfg_ff.bank0_length;
            end
            CSR_BANK0_LENGTH: begin
               map_cfg_in.bank0_length = csr_wdata;
               map_cfg_in.bank1_adjust = bank1_base_ff - csr_wdata;
            end
            CSR_REGION_BOUNDARY: map_cfg_in.region_boundary = csr_wdata;
            CSR_REGION0_LOG2: map_cfg_in.region0_log2 = csr_wdata[LOG2_WIDTH-1:0];
            CSR_REGION1_LOG2: map_cfg_in.region1_log2 = csr_wdata[LOG2_WIDTH-1:0];
            CSR_TIMEOUT: timeout_in = csr_wdata[TIMEOUT_WIDTH-1:0];
            default: ;   // writes past the register list are dropped
         endcase
      end
   end

   // partial word: disabled bytes go out as 0xff so they stay erased
   always_comb begin
      for (int i = 0; i < WORD_BYTES; i++) begin
         packed_word[8*i +: 8] = req_data.byte_enable[i] ? req_data.wdata[8*i +: 8] : 8'hff;
      end
   end

   // decide what this item does
   always_comb begin
      phase_in = phase_ff;
      is_erase_in = is_erase_ff;
      word_address_in = word_address_ff;
      block_address_in = block_address_ff;
      pending_word_in = pending_word_ff;
      last_page_in = last_page_ff;
      poll_count_in = poll_count_ff;

      do_unlock = 1'b0;
      do_operation = 1'b0;
      do_clear_locks = 1'b0;
      do_fail = 1'b0;
      do_done = 1'b0;
      do_poll_read = 1'b0;

      poll_done = ((req_data.wdata & both_halves(ST_READY)) == both_halves(ST_READY))
                  || (poll_count_ff >= timeout_ff);
      status_mask = is_erase_ff ? both_halves(ST_ERASE_ERR | ST_VPEN_LOW | ST_PROTECTED)
                                : both_halves(ST_PROG_ERR | ST_VPEN_LOW | ST_PROTECTED);

      cur_erase = is_erase_ff;
      cur_word = word_address_ff;
      cur_block = block_address_ff;

      if (req_fire) begin
         priority if ((req_data.op == OP_PROGRAM || req_data.op == OP_ERASE)
                      && phase_ff == PH_IDLE) begin
            cur_erase = (req_data.op == OP_ERASE);
            cur_word = map.word_address;
            cur_block = map.block_address;
            is_erase_in = cur_erase;
            word_address_in = cur_word;
            block_address_in = cur_block;
            if (cur_erase) begin
               do_unlock = 1'b1;           // erase always checks the locks
            end else begin
               pending_word_in = packed_word;
               last_page_in = map.page;
               // program unlocks only on a page change
               if (map.page != last_page_ff) begin
                  do_unlock = 1'b1;
               end else begin
                  do_operation = 1'b1;
               end
            end
         end else if (req_data.op == OP_TICK) begin
            // ticks count only while polling, saturating
            if ((phase_ff == PH_UNLOCK_POLL || phase_ff == PH_OP_POLL)
                && poll_count_ff != '1) begin
               poll_count_in = poll_count_ff + TIMEOUT_WIDTH'(1);
            end
         end else if (req_data.op == OP_READ_DATA) begin
            unique case (phase_ff)
               PH_LOCK_WAIT: begin
                  if ((req_data.wdata & both_halves(ID_LOCKED)) == '0) begin
                     do_operation = 1'b1;
                  end else begin
                     do_clear_locks = 1'b1;
                  end
               end
               PH_UNLOCK_POLL: begin
                  if (!poll_done) begin
                     do_poll_read = 1'b1;
                  end else if ((req_data.wdata
                                & both_halves(ST_PROG_ERR | ST_VPEN_LOW | ST_PROTECTED))
                               != '0) begin
                     do_fail = 1'b1;
                  end else begin
                     do_operation = 1'b1;
                  end
               end
               PH_OP_POLL: begin
                  if (!poll_done) begin
                     do_poll_read = 1'b1;
                  end else if ((req_data.wdata & status_mask) != '0) begin
                     do_fail = 1'b1;
                  end else begin
                     do_done = 1'b1;
                  end
               end
               default: ;   // stray read data in idle
            endcase
         end else begin
            // program or erase while busy is dropped
         end
      end

      target = cur_erase ? cur_block : cur_word;

      // build the bus words
      for (int i = 0; i < RSP_DEPTH; i++) begin
         rsp_new[i] = '0;
      end
      new_cnt = 2'd0;

      priority if (do_unlock) begin
         rsp_new[0] = make_rsp(KIND_WRITE, cur_block, both_halves(CMD_READ_ID));
         rsp_new[1] = make_rsp(KIND_READ, cur_block + DATA_WIDTH'(8), '0);
         new_cnt = 2'd2;
         phase_in = PH_LOCK_WAIT;
      end else if (do_operation) begin
         if (cur_erase) begin
            rsp_new[0] = make_rsp(KIND_WRITE, cur_block, both_halves(CMD_ERASE));
            rsp_new[1] = make_rsp(KIND_WRITE, cur_block, both_halves(CMD_CONFIRM));
         end else begin
            rsp_new[0] = make_rsp(KIND_WRITE, cur_word, both_halves(CMD_PROGRAM));
            rsp_new[1] = make_rsp(KIND_WRITE, cur_word, pending_word_in);
         end
         rsp_new[2] = make_rsp(KIND_READ, target, '0);
         new_cnt = 2'd3;
         poll_count_in = '0;
         phase_in = PH_OP_POLL;
      end else if (do_clear_locks) begin
         rsp_new[0] = make_rsp(KIND_WRITE, cur_block, both_halves(CMD_CONFIGURE));
         rsp_new[1] = make_rsp(KIND_WRITE, cur_block, both_halves(CMD_CONFIRM));
         rsp_new[2] = make_rsp(KIND_READ, cur_block, '0);
         new_cnt = 2'd3;
         poll_count_in = '0;
         phase_in = PH_UNLOCK_POLL;
      end else if (do_fail) begin
         rsp_new[0] = make_rsp(KIND_WRITE, target, both_halves(CMD_CLEAR_STATUS));
         rsp_new[1] = make_rsp(KIND_FAIL, target, req_data.wdata);
         new_cnt = 2'd2;
         last_page_in = '1;
         phase_in = PH_IDLE;
      end else if (do_done) begin
         rsp_new[0] = make_rsp(KIND_DONE, target, req_data.wdata);
         new_cnt = 2'd1;
         phase_in = PH_IDLE;
      end else if (do_poll_read) begin
         // unlock polling reads the block, operation polling its own target
         rsp_new[0] = make_rsp(KIND_READ,
                               (phase_ff == PH_UNLOCK_POLL) ? cur_block : target, '0);
         new_cnt = 2'd1;
      end else begin
         // nothing to send
      end

      for (int i = 0; i < RSP_DEPTH; i++) begin
         rsp_new[i].last = (new_cnt == 2'(i + 1));
      end
   end

   // buffer count: a new item replaces the buffer, else a pop shifts it
   always_comb begin
      rsp_cnt_in = rsp_cnt_ff;
      if (req_fire) begin
         rsp_cnt_in = new_cnt;
      end else if (rsp_pop) begin
         rsp_cnt_in = rsp_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_cfg_ff.bank0_base <= '0;
         map_cfg_ff.bank1_adjust <= DATA_WIDTH'(0) - BANK0_LENGTH_RESET;
         map_cfg_ff.bank0_length <= BANK0_LENGTH_RESET;
         map_cfg_ff.region_boundary <= REGION_BOUNDARY_RESET;
         map_cfg_ff.region0_log2 <= BLOCK_LOG2_RESET;
         map_cfg_ff.region1_log2 <= BLOCK_LOG2_RESET;
         bank1_base_ff <= '0;
         timeout_ff <= TIMEOUT_RESET;
         phase_ff <= PH_IDLE;
         is_erase_ff <= 1'b0;
         word_address_ff <= '0;
         block_address_ff <= '0;
         pending_word_ff <= '1;
         last_page_ff <= '1;
         poll_count_ff <= '0;
         rsp_cnt_ff <= 2'd0;
      end else begin
         map_cfg_ff <= map_cfg_in;
         bank1_base_ff <= bank1_base_in;
         timeout_ff <= timeout_in;
         phase_ff <= phase_in;
         is_erase_ff <= is_erase_in;
         word_address_ff <= word_address_in;
         block_address_ff <= block_address_in;
         pending_word_ff <= pending_word_in;
         last_page_ff <= last_page_in;
         poll_count_ff <= poll_count_in;
         rsp_cnt_ff <= rsp_cnt_in;
      end
   end

   // buffered words carry no reset; the count says which are live
   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < RSP_DEPTH; i++) begin
            rsp_buf_ff[i] <= rsp_new[i];
         end
      end else if (rsp_pop) begin
         for (int i = 0; i < RSP_DEPTH - 1; i++) begin
            rsp_buf_ff[i] <= rsp_buf_ff[i + 1];
         end
      end
   end

   // the word marked last is always the final one in the buffer
   `ASSERT_IMPLIES(a_last_at_tail, clock, reset, rsp_valid,
      rsp_data.last == (rsp_cnt_ff == 2'd1), "last flag does not match buffer tail")

   // a done or failed word only goes out once the sequencer is back in idle
   `ASSERT_IMPLIES(a_end_in_idle, clock, reset,
      rsp_valid && (rsp_data.kind == KIND_DONE || rsp_data.kind == KIND_FAIL),
      phase_ff == PH_IDLE, "completion word while sequencer busy")

   // a program taken in idle always starts bus traffic
   `ASSERT_NEXT(a_program_emits, clock, reset,
      req_fire && req_data.op == OP_PROGRAM && phase_ff == PH_IDLE,
      rsp_valid && rsp_cnt_ff >= 2'd2, "program request produced no bus words")

endmodule

`default_nettype wire
